// ----- rtl/plist_pkg.sv -----
// Shared types and codes for the positional list engine.
package plist_pkg;

	localparam int CW = 7;
	localparam int DW = 32;

	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_APPEND = 3'd1;
	localparam logic [2:0] CMD_READ   = 3'd2;
	localparam logic [2:0] CMD_DELETE = 3'd3;
	localparam logic [2:0] CMD_INSERT = 3'd4;
	localparam logic [2:0] CMD_SEARCH = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_POS   = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [2:0]           cmd;
		logic [CW-1:0]        position;
		logic signed [DW-1:0] value;
	} item_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [CW-1:0]        found_position;
		logic signed [DW-1:0] entry_value;
		logic [CW-1:0]        entry_count;
		logic                 last;
	} result_t;

	typedef struct packed {
		logic load;
		logic init;
		logic issue;
		logic proc;
		logic fin;
	} ctl_t;

	typedef struct packed {
		logic walk_more;
		logic rd_vld;
		logic need_slot;
		logic out_free;
		logic fin_emit;
	} sts_t;

endpackage

// ----- rtl/positional_list_engine.sv -----
// Positional list engine top level: ordered list with insert, delete, search.
//
//   channel   handshake                    payload
//   item      item_valid / item_ready      item   (cmd, position, value)
//   result    result_valid / result_ready  result (status, found_position,
//                                                  entry_value, entry_count, last)
//
// One command is taken at a time; the entry memory (one read and one write port) is
// walked one entry per cycle while the result channel is not stalled, r entries in
// all (count for read all and search, count - position + 1 for a valid delete or
// insert, none otherwise).
// A stalled result channel holds the walk at the entry waiting to go out.
// Reset empties the list; entry storage is not cleared.
module positional_list_engine
	import plist_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	ctl_t ctl;
	sts_t sts;

	plist_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.ctl        (ctl)
	);

	plist_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

// ----- rtl/plist_ctrl.sv -----
// Command sequencer: accept, set up the walk, walk the list, finish.
module plist_ctrl
	import plist_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INIT = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		ctl        = '0;
		state_d    = state_q;
		item_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					ctl.load = 1'b1;
					state_d  = S_INIT;
				end
			end
			S_INIT: begin
				ctl.init = 1'b1;
				state_d  = S_WALK;
			end
			S_WALK: begin
				// The read stage drains only when its result can go out.
				ctl.proc  = sts.rd_vld && (!sts.need_slot || sts.out_free);
				ctl.issue = sts.walk_more && (!sts.rd_vld || ctl.proc);
				if (!sts.walk_more && !sts.rd_vld) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.fin_emit || sts.out_free) begin
					ctl.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/plist_dp.sv -----
// Datapath: entry memory, count, walk index, match holding and result register.
module plist_dp
	import plist_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  ctl_t    ctl,
	output sts_t    sts,
	input  item_t   item,
	output result_t result,
	output logic    result_valid,
	input  logic    result_ready
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic signed [DW-1:0] mem [DEPTH];

	item_t                req_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        rem_q;
	logic                 dn_q;
	logic                 rd_vld_s1;
	logic [CW-1:0]        rd_idx_s1;
	logic signed [DW-1:0] rdata_s1;
	logic                 hm_vld_q;
	logic [CW-1:0]        hm_pos_q;
	logic signed [DW-1:0] hm_val_q;
	logic                 out_vld_q;
	result_t              out_q;

	logic [CW-1:0]        pos_m1;
	logic [CW-1:0]        cnt_p1;
	logic [CW-1:0]        cnt_m1;
	logic                 del_bad;
	logic                 ins_bad;
	logic                 full;
	logic                 match;
	logic                 out_free;

	logic [CW-1:0]        init_idx;
	logic [CW-1:0]        init_rem;
	logic                 init_dn;

	logic                 wr_en;
	logic [CW-1:0]        wr_addr;
	logic signed [DW-1:0] wr_data;
	logic                 emit;
	result_t              emit_res;
	logic                 cnt_ld;
	logic [CW-1:0]        cnt_d;

	assign pos_m1   = req_q.position - CW'(1);
	assign cnt_p1   = cnt_q + CW'(1);
	assign cnt_m1   = cnt_q - CW'(1);
	assign del_bad  = (req_q.position == '0) || (req_q.position > cnt_q);
	assign ins_bad  = (req_q.position == '0) || (req_q.position > cnt_p1);
	assign full     = (cnt_q >= DEPTH_C);
	assign match    = (rdata_s1 == req_q.value);
	assign out_free = !out_vld_q || result_ready;

	always_comb begin
		sts.walk_more = (rem_q != '0);
		sts.rd_vld    = rd_vld_s1;
		sts.out_free  = out_free;
		case (req_q.cmd)
			CMD_READ:   sts.need_slot = 1'b1;
			CMD_SEARCH: sts.need_slot = match && hm_vld_q;
			default:    sts.need_slot = 1'b0;
		endcase
		case (req_q.cmd) inside
			CMD_CLEAR, CMD_APPEND, CMD_DELETE, CMD_INSERT, CMD_SEARCH: sts.fin_emit = 1'b1;
			CMD_READ: sts.fin_emit = (cnt_q == '0);
			default:  sts.fin_emit = 1'b0;
		endcase
	end

	// Walk range: delete reads upward from the removed slot, insert reads
	// downward from the tail so that each entry moves before it is overwritten.
	always_comb begin
		init_idx = '0;
		init_rem = '0;
		init_dn  = 1'b0;
		case (req_q.cmd) inside
			CMD_READ, CMD_SEARCH: begin
				init_rem = cnt_q;
			end
			CMD_DELETE: begin
				if (!del_bad) begin
					init_idx = pos_m1;
					init_rem = cnt_q - pos_m1;
				end
			end
			CMD_INSERT: begin
				if (!ins_bad && !full) begin
					init_idx = cnt_m1;
					init_rem = cnt_p1 - req_q.position;
					init_dn  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = cnt_q;
		wr_data  = req_q.value;
		emit     = 1'b0;
		cnt_ld   = 1'b0;
		cnt_d    = cnt_q;
		emit_res = '{status: ST_OK, found_position: '0, entry_value: '0,
			entry_count: cnt_q, last: 1'b1};
		if (ctl.proc) begin
			case (req_q.cmd)
				CMD_READ: begin
					emit                    = 1'b1;
					emit_res.found_position = rd_idx_s1 + CW'(1);
					emit_res.entry_value    = rdata_s1;
					emit_res.last           = (rd_idx_s1 == cnt_m1);
				end
				CMD_SEARCH: begin
					// A new match releases the one held before it.
					if (match && hm_vld_q) begin
						emit                    = 1'b1;
						emit_res.found_position = hm_pos_q;
						emit_res.entry_value    = hm_val_q;
						emit_res.last           = 1'b0;
					end
				end
				CMD_DELETE: begin
					if (rd_idx_s1 != pos_m1) begin
						wr_en   = 1'b1;
						wr_addr = rd_idx_s1 - CW'(1);
						wr_data = rdata_s1;
					end
				end
				CMD_INSERT: begin
					wr_en   = 1'b1;
					wr_addr = rd_idx_s1 + CW'(1);
					wr_data = rdata_s1;
				end
				default: ;
			endcase
		end
		if (ctl.fin) begin
			case (req_q.cmd)
				CMD_CLEAR: begin
					emit                 = 1'b1;
					cnt_ld               = 1'b1;
					cnt_d                = '0;
					emit_res.entry_count = '0;
				end
				CMD_APPEND: begin
					emit = 1'b1;
					if (full) begin
						emit_res.status = ST_FULL;
					end else begin
						wr_en                   = 1'b1;
						cnt_ld                  = 1'b1;
						cnt_d                   = cnt_p1;
						emit_res.found_position = cnt_p1;
						emit_res.entry_value    = req_q.value;
						emit_res.entry_count    = cnt_p1;
					end
				end
				CMD_READ: begin
					emit = (cnt_q == '0);
				end
				CMD_DELETE: begin
					emit = 1'b1;
					if (del_bad) begin
						emit_res.status = ST_BAD_POS;
					end else begin
						cnt_ld                  = 1'b1;
						cnt_d                   = cnt_m1;
						emit_res.found_position = req_q.position;
						emit_res.entry_value    = hm_val_q;
						emit_res.entry_count    = cnt_m1;
					end
				end
				CMD_INSERT: begin
					emit = 1'b1;
					if (ins_bad) begin
						emit_res.status = ST_BAD_POS;
					end else if (full) begin
						emit_res.status = ST_FULL;
					end else begin
						wr_en                   = 1'b1;
						wr_addr                 = pos_m1;
						cnt_ld                  = 1'b1;
						cnt_d                   = cnt_p1;
						emit_res.found_position = req_q.position;
						emit_res.entry_value    = req_q.value;
						emit_res.entry_count    = cnt_p1;
					end
				end
				CMD_SEARCH: begin
					emit = 1'b1;
					if (hm_vld_q) begin
						emit_res.found_position = hm_pos_q;
						emit_res.entry_value    = hm_val_q;
					end else begin
						emit_res.status = ST_NOT_FOUND;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[AW-1:0]] <= wr_data;
		end
		if (ctl.issue) begin
			rdata_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rem_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hm_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cnt_ld) begin
				cnt_q <= cnt_d;
			end
			if (ctl.init) begin
				rem_q <= init_rem;
			end else if (ctl.issue) begin
				rem_q <= rem_q - CW'(1);
			end
			if (ctl.init) begin
				rd_vld_s1 <= 1'b0;
			end else if (ctl.issue) begin
				rd_vld_s1 <= 1'b1;
			end else if (ctl.proc) begin
				rd_vld_s1 <= 1'b0;
			end
			if (ctl.init) begin
				hm_vld_q <= 1'b0;
			end else if (ctl.proc && req_q.cmd == CMD_SEARCH && match) begin
				hm_vld_q <= 1'b1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= item;
		end
		if (ctl.init) begin
			idx_q <= init_idx;
			dn_q  <= init_dn;
		end else if (ctl.issue) begin
			idx_q <= dn_q ? (idx_q - CW'(1)) : (idx_q + CW'(1));
		end
		if (ctl.issue) begin
			rd_idx_s1 <= idx_q;
		end
		if (ctl.proc && req_q.cmd == CMD_SEARCH && match) begin
			hm_pos_q <= rd_idx_s1 + CW'(1);
			hm_val_q <= rdata_s1;
		end else if (ctl.proc && req_q.cmd == CMD_DELETE && rd_idx_s1 == pos_m1) begin
			hm_val_q <= rdata_s1;
		end
		if (emit) begin
			out_q <= emit_res;
		end
	end

	assign result       = out_q;
	assign result_valid = out_vld_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("entry count exceeds list depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result register overwritten before its transaction");

	a_walk_drained: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |-> (!rd_vld_s1 && rem_q == '0))
		else $error("command finished with list walk still in flight");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.issue |-> (idx_q < DEPTH_C && idx_q < cnt_q))
		else $error("memory read outside the held entries");

endmodule
